[src/ctl_pkg.sv]
// ----------------------------------------------------------------------------
// ctl_pkg: shared types and constants of the C token lexer
// Token kinds, lexer phase codes, keyword table and lookup, the result item type and the lexer state type.
// ----------------------------------------------------------------------------
package ctl_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int KEYWORD_CHARS  = 8;
    localparam int MAX_TOKENS     = 3;

    localparam logic [6:0] K_EOF      = 7'd0;
    localparam logic [6:0] K_IDENT    = 7'd1;
    localparam logic [6:0] K_NUMBER   = 7'd2;
    localparam logic [6:0] K_UNKNOWN  = 7'd3;
    localparam logic [6:0] K_KW_BASE  = 7'd4;

    localparam logic [6:0] P_LSQ      = 7'd36;
    localparam logic [6:0] P_RSQ      = 7'd37;
    localparam logic [6:0] P_LPAR     = 7'd38;
    localparam logic [6:0] P_RPAR     = 7'd39;
    localparam logic [6:0] P_LBR      = 7'd40;
    localparam logic [6:0] P_RBR      = 7'd41;
    localparam logic [6:0] P_ELLIP    = 7'd42;
    localparam logic [6:0] P_DOT      = 7'd43;
    localparam logic [6:0] P_AMPAMP   = 7'd44;
    localparam logic [6:0] P_AMPEQ    = 7'd45;
    localparam logic [6:0] P_AMP      = 7'd46;
    localparam logic [6:0] P_STAREQ   = 7'd47;
    localparam logic [6:0] P_STAR     = 7'd48;
    localparam logic [6:0] P_PLUSPLUS = 7'd49;
    localparam logic [6:0] P_PLUSEQ   = 7'd50;
    localparam logic [6:0] P_PLUS     = 7'd51;
    localparam logic [6:0] P_ARROW    = 7'd52;
    localparam logic [6:0] P_MINMIN   = 7'd53;
    localparam logic [6:0] P_MINEQ    = 7'd54;
    localparam logic [6:0] P_MINUS    = 7'd55;
    localparam logic [6:0] P_TILDE    = 7'd56;
    localparam logic [6:0] P_EXCLEQ   = 7'd57;
    localparam logic [6:0] P_EXCL     = 7'd58;
    localparam logic [6:0] P_SLASHEQ  = 7'd59;
    localparam logic [6:0] P_SLASH    = 7'd60;
    localparam logic [6:0] P_PCTEQ    = 7'd61;
    localparam logic [6:0] P_PCT      = 7'd62;
    localparam logic [6:0] P_SHLEQ    = 7'd63;
    localparam logic [6:0] P_SHL      = 7'd64;
    localparam logic [6:0] P_LE       = 7'd65;
    localparam logic [6:0] P_LT       = 7'd66;
    localparam logic [6:0] P_SHREQ    = 7'd67;
    localparam logic [6:0] P_SHR      = 7'd68;
    localparam logic [6:0] P_GE       = 7'd69;
    localparam logic [6:0] P_GT       = 7'd70;
    localparam logic [6:0] P_CARETEQ  = 7'd71;
    localparam logic [6:0] P_CARET    = 7'd72;
    localparam logic [6:0] P_PIPEPIPE = 7'd73;
    localparam logic [6:0] P_PIPEEQ   = 7'd74;
    localparam logic [6:0] P_PIPE     = 7'd75;
    localparam logic [6:0] P_QUEST    = 7'd76;
    localparam logic [6:0] P_COLON    = 7'd77;
    localparam logic [6:0] P_SEMI     = 7'd78;
    localparam logic [6:0] P_EQEQ     = 7'd79;
    localparam logic [6:0] P_EQ       = 7'd80;
    localparam logic [6:0] P_COMMA    = 7'd81;
    localparam logic [6:0] P_HASHHASH = 7'd82;
    localparam logic [6:0] P_HASHAT   = 7'd83;
    localparam logic [6:0] P_HASH     = 7'd84;

    localparam logic [6:0] PH_IDLE    = 7'd0;
    localparam logic [6:0] PH_IDENT   = 7'd1;
    localparam logic [6:0] PH_NUMBER  = 7'd2;
    localparam logic [6:0] PH_DOTDOT  = 7'd85;

    typedef struct packed {
        logic [6:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [63:0] val;
        logic        ovf;
    } t_tok;

    typedef struct packed {
        logic [POSITION_WIDTH-1:0] pos;
        logic [POSITION_WIDTH-1:0] tstart;
        logic [6:0]                phase;
        logic [15:0]               wlen;
        logic [63:0]               acc;
        logic                      ovf;
    } t_lex_state;

    localparam logic [63:0] KW_TEXT [32] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "int", "long", "register", "return", "short", "signed", "sizeof",
        "static", "struct", "switch", "typedef", "union", "unsigned", "void",
        "volatile", "while"
    };

    localparam logic [3:0] KW_LEN [32] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
        4'd8, 4'd5
    };

    // prefix holds character i at bits [8*i +: 8]
    function automatic logic [6:0] kw_kind(input logic [8*KEYWORD_CHARS-1:0] prefix,
                                           input logic [15:0] wlen);
        logic [6:0] k;
        logic       hit;
        int         sel;
        k = K_IDENT;
        for (int j = 31; j >= 0; j--) begin
            hit = (wlen == {12'd0, KW_LEN[j]});
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
                sel = (i < int'(KW_LEN[j])) ? (int'(KW_LEN[j]) - 1 - i) : 0;
                if (i < int'(KW_LEN[j]) && prefix[8*i +: 8] != KW_TEXT[j][8*sel +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = 7'(K_KW_BASE + 7'(j));
            end
        end
        return k;
    endfunction

endpackage

[src/c_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// c_token_lexer_unit: streaming C tokenizer
// Takes one source byte per transaction and emits the tokens it decides.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry i_byte_in and i_end_mark.
// A byte with i_end_mark high flushes the pending token and yields eof;
// positions restart at zero after it.
// Output channel: o_out_valid / i_out_ready carry one token per transaction,
// o_last_of_run marks the last token caused by one input transaction.
// Tokens are registered and appear in the cycle after the input transaction
// that decides them. Throughput: one byte per cycle while each byte yields at
// most one token and the output is not stalled; a byte yielding more tokens
// holds the input until the result register hands out its last token.
// Reset clears the lexer state and drops any buffered tokens.
// A stall on the output holds the buffered tokens and deasserts o_in_ready
// once the last buffered token is not being taken.
// ----------------------------------------------------------------------------
module c_token_lexer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    input  logic        i_end_mark,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_token_kind,
    output logic [15:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [63:0] o_number_value,
    output logic        o_number_overflow,
    output logic        o_last_of_run
);

    ctl_pkg::t_lex_state r_state, n_state;
    logic [7:0]          r_prefix [ctl_pkg::KEYWORD_CHARS];
    logic [8*ctl_pkg::KEYWORD_CHARS-1:0] prefix_flat;
    logic                pre_we;
    logic [2:0]          pre_idx;
    logic [7:0]          pre_data;
    ctl_pkg::t_tok       step_tok [ctl_pkg::MAX_TOKENS];
    logic [1:0]          step_count;
    ctl_pkg::t_tok       out_tok;
    logic                accept;

    always_comb begin
        for (int i = 0; i < ctl_pkg::KEYWORD_CHARS; i++) begin
            prefix_flat[8*i +: 8] = r_prefix[i];
        end
    end

    assign accept = i_in_valid && o_in_ready;

    ctl_step u_step (
        .i_state    (r_state),
        .i_prefix   (prefix_flat),
        .i_byte_in  (i_byte_in),
        .i_end_mark (i_end_mark),
        .o_state    (n_state),
        .o_pre_we   (pre_we),
        .o_pre_idx  (pre_idx),
        .o_pre_data (pre_data),
        .o_tok      (step_tok),
        .o_count    (step_count)
    );

    ctl_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_tok       (step_tok),
        .i_count     (step_count),
        .i_out_ready (i_out_ready),
        .o_can_load  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_tok       (out_tok),
        .o_last      (o_last_of_run)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pre_we) begin
            r_prefix[pre_idx] <= pre_data;
        end
    end

    assign o_token_kind      = out_tok.kind;
    assign o_start_offset    = out_tok.start;
    assign o_token_length    = out_tok.len;
    assign o_number_value    = out_tok.val;
    assign o_number_overflow = out_tok.ovf;

`ifndef SYNTHESIS
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == ctl_pkg::K_EOF) |-> o_last_of_run)
        else $error("eof token not last of run");

    a_ovf_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_number_overflow) |-> (o_token_kind == ctl_pkg::K_NUMBER))
        else $error("overflow flag on non-number token");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule

[src/ctl_step.sv]
// ----------------------------------------------------------------------------
// ctl_step: next-state and token logic for one source byte
// Decides the lexer state update and up to three tokens per transaction.
// ----------------------------------------------------------------------------
module ctl_step (
    input  ctl_pkg::t_lex_state                        i_state,
    input  logic [8*ctl_pkg::KEYWORD_CHARS-1:0]        i_prefix,
    input  logic [7:0]                                 i_byte_in,
    input  logic                                       i_end_mark,
    output ctl_pkg::t_lex_state                        o_state,
    output logic                                       o_pre_we,
    output logic [2:0]                                 o_pre_idx,
    output logic [7:0]                                 o_pre_data,
    output ctl_pkg::t_tok                              o_tok [ctl_pkg::MAX_TOKENS],
    output logic [1:0]                                 o_count
);

    logic        is_space, is_digit, is_head, is_punct;
    logic [3:0]  digit;
    logic [6:0]  ext2, start_kind;
    logic        start_wait;
    logic [67:0] prod;
    logic        dig_ovf;
    logic [63:0] dig_acc;
    logic [6:0]  p;
    logic [7:0]  c;
    logic [1:0]  n;
    logic        do_flush;

    assign c = i_byte_in;
    assign p = i_state.phase;

    assign is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0C) || (c == 8'h0B)
                   || (c == 8'h0D) || (c == 8'h0A);
    assign is_digit = (c >= "0") && (c <= "9");
    assign is_head  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign digit    = 4'(c - "0");
    assign is_punct = (p >= ctl_pkg::P_LSQ) && (p <= ctl_pkg::P_HASH);

    always_comb begin
        prod    = ({4'd0, i_state.acc} << 3) + ({4'd0, i_state.acc} << 1) + {64'd0, digit};
        dig_ovf = i_state.ovf || (prod[67:64] != 4'd0);
        dig_acc = dig_ovf ? {64{1'b1}} : prod[63:0];
    end

    always_comb begin
        ext2 = ctl_pkg::PH_IDLE;
        case (p)
            ctl_pkg::P_AMP:   ext2 = (c == "&") ? ctl_pkg::P_AMPAMP
                                   : (c == "=") ? ctl_pkg::P_AMPEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_STAR:  ext2 = (c == "=") ? ctl_pkg::P_STAREQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_PLUS:  ext2 = (c == "+") ? ctl_pkg::P_PLUSPLUS
                                   : (c == "=") ? ctl_pkg::P_PLUSEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_MINUS: ext2 = (c == ">") ? ctl_pkg::P_ARROW
                                   : (c == "-") ? ctl_pkg::P_MINMIN
                                   : (c == "=") ? ctl_pkg::P_MINEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_EXCL:  ext2 = (c == "=") ? ctl_pkg::P_EXCLEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_SLASH: ext2 = (c == "=") ? ctl_pkg::P_SLASHEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_PCT:   ext2 = (c == "=") ? ctl_pkg::P_PCTEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_LT:    ext2 = (c == "=") ? ctl_pkg::P_LE : ctl_pkg::PH_IDLE;
            ctl_pkg::P_GT:    ext2 = (c == "=") ? ctl_pkg::P_GE : ctl_pkg::PH_IDLE;
            ctl_pkg::P_CARET: ext2 = (c == "=") ? ctl_pkg::P_CARETEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_PIPE:  ext2 = (c == "|") ? ctl_pkg::P_PIPEPIPE
                                   : (c == "=") ? ctl_pkg::P_PIPEEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_EQ:    ext2 = (c == "=") ? ctl_pkg::P_EQEQ : ctl_pkg::PH_IDLE;
            ctl_pkg::P_HASH:  ext2 = (c == "#") ? ctl_pkg::P_HASHHASH
                                   : (c == "@") ? ctl_pkg::P_HASHAT : ctl_pkg::PH_IDLE;
            default:          ext2 = ctl_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        start_wait = 1'b1;
        start_kind = ctl_pkg::K_UNKNOWN;
        case (c)
            "[": begin start_kind = ctl_pkg::P_LSQ;   start_wait = 1'b0; end
            "]": begin start_kind = ctl_pkg::P_RSQ;   start_wait = 1'b0; end
            "(": begin start_kind = ctl_pkg::P_LPAR;  start_wait = 1'b0; end
            ")": begin start_kind = ctl_pkg::P_RPAR;  start_wait = 1'b0; end
            "{": begin start_kind = ctl_pkg::P_LBR;   start_wait = 1'b0; end
            "}": begin start_kind = ctl_pkg::P_RBR;   start_wait = 1'b0; end
            "~": begin start_kind = ctl_pkg::P_TILDE; start_wait = 1'b0; end
            "?": begin start_kind = ctl_pkg::P_QUEST; start_wait = 1'b0; end
            ":": begin start_kind = ctl_pkg::P_COLON; start_wait = 1'b0; end
            ";": begin start_kind = ctl_pkg::P_SEMI;  start_wait = 1'b0; end
            ",": begin start_kind = ctl_pkg::P_COMMA; start_wait = 1'b0; end
            ".": start_kind = ctl_pkg::P_DOT;
            "&": start_kind = ctl_pkg::P_AMP;
            "*": start_kind = ctl_pkg::P_STAR;
            "+": start_kind = ctl_pkg::P_PLUS;
            "-": start_kind = ctl_pkg::P_MINUS;
            "!": start_kind = ctl_pkg::P_EXCL;
            "/": start_kind = ctl_pkg::P_SLASH;
            "%": start_kind = ctl_pkg::P_PCT;
            "<": start_kind = ctl_pkg::P_LT;
            ">": start_kind = ctl_pkg::P_GT;
            "^": start_kind = ctl_pkg::P_CARET;
            "|": start_kind = ctl_pkg::P_PIPE;
            "=": start_kind = ctl_pkg::P_EQ;
            "#": start_kind = ctl_pkg::P_HASH;
            default: begin start_kind = ctl_pkg::K_UNKNOWN; start_wait = 1'b0; end
        endcase
    end

    always_comb begin
        o_state    = i_state;
        o_pre_we   = 1'b0;
        o_pre_idx  = 3'd0;
        o_pre_data = c;
        for (int t = 0; t < ctl_pkg::MAX_TOKENS; t++) begin
            o_tok[t] = '0;
        end
        n        = 2'd0;
        do_flush = 1'b0;

        if (i_end_mark) begin
            do_flush = 1'b1;
        end else if (p == ctl_pkg::PH_IDENT && (is_head || is_digit)) begin
            if (i_state.wlen < 16'(ctl_pkg::KEYWORD_CHARS)) begin
                o_pre_we  = 1'b1;
                o_pre_idx = i_state.wlen[2:0];
            end
            if (i_state.wlen != 16'hFFFF) begin
                o_state.wlen = i_state.wlen + 16'd1;
            end
        end else if (p == ctl_pkg::PH_NUMBER && is_digit) begin
            o_state.acc = dig_acc;
            o_state.ovf = dig_ovf;
            if (i_state.wlen != 16'hFFFF) begin
                o_state.wlen = i_state.wlen + 16'd1;
            end
        end else if (p == ctl_pkg::PH_DOTDOT && c == ".") begin
            o_tok[0]       = '{ctl_pkg::P_ELLIP, i_state.tstart, 16'd3, 64'd0, 1'b0};
            n              = 2'd1;
            o_state.phase  = ctl_pkg::PH_IDLE;
        end else if ((p == ctl_pkg::P_SHL || p == ctl_pkg::P_SHR) && c == "=") begin
            o_tok[0]       = '{(p == ctl_pkg::P_SHL) ? ctl_pkg::P_SHLEQ : ctl_pkg::P_SHREQ,
                               i_state.tstart, 16'd3, 64'd0, 1'b0};
            n              = 2'd1;
            o_state.phase  = ctl_pkg::PH_IDLE;
        end else if (p == ctl_pkg::P_DOT && c == ".") begin
            o_state.phase = ctl_pkg::PH_DOTDOT;
        end else if (p == ctl_pkg::P_LT && c == "<") begin
            o_state.phase = ctl_pkg::P_SHL;
        end else if (p == ctl_pkg::P_GT && c == ">") begin
            o_state.phase = ctl_pkg::P_SHR;
        end else if (is_punct && ext2 != ctl_pkg::PH_IDLE) begin
            o_tok[0]       = '{ext2, i_state.tstart, 16'd2, 64'd0, 1'b0};
            n              = 2'd1;
            o_state.phase  = ctl_pkg::PH_IDLE;
        end else begin
            do_flush = 1'b1;
        end

        if (do_flush) begin
            o_state.phase = ctl_pkg::PH_IDLE;
            if (p == ctl_pkg::PH_IDENT) begin
                o_tok[0] = '{ctl_pkg::kw_kind(i_prefix, i_state.wlen), i_state.tstart,
                             i_state.wlen, 64'd0, 1'b0};
                n        = 2'd1;
            end else if (p == ctl_pkg::PH_NUMBER) begin
                o_tok[0] = '{ctl_pkg::K_NUMBER, i_state.tstart, i_state.wlen,
                             i_state.acc, i_state.ovf};
                n        = 2'd1;
            end else if (p == ctl_pkg::PH_DOTDOT) begin
                o_tok[0] = '{ctl_pkg::P_DOT, i_state.tstart, 16'd1, 64'd0, 1'b0};
                o_tok[1] = '{ctl_pkg::P_DOT, i_state.tstart + 16'd1, 16'd1, 64'd0, 1'b0};
                n        = 2'd2;
            end else if (is_punct) begin
                o_tok[0] = '{p, i_state.tstart,
                             (p == ctl_pkg::P_SHL || p == ctl_pkg::P_SHR) ? 16'd2 : 16'd1,
                             64'd0, 1'b0};
                n        = 2'd1;
            end

            if (i_end_mark) begin
                o_tok[n] = '{ctl_pkg::K_EOF, i_state.pos, 16'd0, 64'd0, 1'b0};
                n        = n + 2'd1;
                o_state.tstart = '0;
                o_state.wlen   = 16'd0;
                o_state.acc    = 64'd0;
                o_state.ovf    = 1'b0;
            end else if (!is_space) begin
                o_state.tstart = i_state.pos;
                if (is_head) begin
                    o_pre_we      = 1'b1;
                    o_pre_idx     = 3'd0;
                    o_state.wlen  = 16'd1;
                    o_state.phase = ctl_pkg::PH_IDENT;
                end else if (is_digit) begin
                    o_state.acc   = {60'd0, digit};
                    o_state.ovf   = 1'b0;
                    o_state.wlen  = 16'd1;
                    o_state.phase = ctl_pkg::PH_NUMBER;
                end else if (start_wait) begin
                    o_state.phase = start_kind;
                end else begin
                    o_tok[n] = '{start_kind, i_state.pos, 16'd1, 64'd0, 1'b0};
                    n        = n + 2'd1;
                end
            end
        end

        o_state.pos = i_end_mark ? '0 : i_state.pos + 16'd1;
        o_count     = n;
    end

endmodule

[src/ctl_obuf.sv]
// ----------------------------------------------------------------------------
// ctl_obuf: result register for the tokens of one transaction
// Holds up to three tokens and hands them out one per output transaction.
// ----------------------------------------------------------------------------
module ctl_obuf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  ctl_pkg::t_tok i_tok [ctl_pkg::MAX_TOKENS],
    input  logic [1:0]    i_count,
    input  logic          i_out_ready,
    output logic          o_can_load,
    output logic          o_out_valid,
    output ctl_pkg::t_tok o_tok,
    output logic          o_last
);

    ctl_pkg::t_tok r_tok [ctl_pkg::MAX_TOKENS];
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    r_idx, n_idx;

    assign o_out_valid = (r_idx < r_cnt);
    assign o_last      = ((r_idx + 2'd1) == r_cnt);
    assign o_can_load  = (r_idx == r_cnt) || (o_last && i_out_ready);
    assign o_tok       = r_tok[r_idx];

    always_comb begin
        n_cnt = r_cnt;
        n_idx = r_idx;
        if (i_load) begin
            n_cnt = i_count;
            n_idx = 2'd0;
        end else if (o_out_valid && i_out_ready) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_tok;
        end
    end

endmodule

[sim/tb_c_token_lexer_unit.sv]
// ----------------------------------------------------------------------------
// tb_c_token_lexer_unit: self-checking bench for the streaming C tokenizer
// Feeds bytes and end marks with random gaps on both channels, predicts the
// tokens of every input transaction and compares them in order.
// ----------------------------------------------------------------------------
module tb_c_token_lexer_unit;

    typedef struct {
        logic [6:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [63:0] val;
        logic        ovf;
        logic        last;
    } t_token_exp;

    typedef struct {
        logic [7:0] b;
        logic       e;
        logic       chk;
        logic [6:0] kind;
        logic [15:0] start;
        logic [15:0] len;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_byte_in;
    logic        i_end_mark;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_token_kind;
    logic [15:0] o_start_offset;
    logic [15:0] o_token_length;
    logic [63:0] o_number_value;
    logic        o_number_overflow;
    logic        o_last_of_run;

    c_token_lexer_unit dut (.*);

    // predictor state
    logic [15:0] lx_pos;
    logic [15:0] lx_start;
    logic [6:0]  lx_phase;
    logic [7:0]  lx_prefix [8];
    logic [15:0] lx_wlen;
    logic [63:0] lx_acc;
    logic        lx_ovf;

    t_token_exp  token_fifo[$];
    t_token_exp  run_tokens[$];
    int          fail_count;
    int          n_items;
    bit          stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("status: fail");
        $finish;
    end

    function automatic bit is_ws(logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0c || c == 8'h0b || c == 8'h0d
            || c == 8'h0a;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [6:0] keyword_of();
        string words [32] = '{"auto", "break", "case", "char", "const", "continue",
            "default", "do", "double", "else", "enum", "extern", "float", "for",
            "goto", "if", "int", "long", "register", "return", "short", "signed",
            "sizeof", "static", "struct", "switch", "typedef", "union", "unsigned",
            "void", "volatile", "while"};
        bit hit;
        if (lx_wlen > 8) return ctl_pkg::K_IDENT;
        for (int j = 0; j < 32; j++) begin
            hit = (words[j].len() == lx_wlen);
            for (int i = 0; i < words[j].len() && hit; i++)
                if (lx_prefix[i] != words[j][i]) hit = 0;
            if (hit) return 7'(ctl_pkg::K_KW_BASE + j);
        end
        return ctl_pkg::K_IDENT;
    endfunction

    function automatic void push_token(logic [6:0] k, logic [15:0] s, logic [15:0] l,
                                       logic [63:0] v, logic o);
        t_token_exp t;
        if (run_tokens.size() >= ctl_pkg::MAX_TOKENS) return;
        t.kind = k; t.start = s; t.len = l; t.val = v; t.ovf = o; t.last = 0;
        run_tokens.push_back(t);
    endfunction

    function automatic void add_digit(logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - "0");
        if (lx_ovf || lx_acc > (64'hffff_ffff_ffff_ffff - d) / 10) begin
            lx_acc = '1;
            lx_ovf = 1;
        end else begin
            lx_acc = lx_acc * 10 + d;
        end
    endfunction

    function automatic void flush_word();
        case (lx_phase)
            ctl_pkg::PH_IDLE: ;
            ctl_pkg::PH_IDENT: push_token(keyword_of(), lx_start, lx_wlen, 0, 0);
            ctl_pkg::PH_NUMBER: push_token(ctl_pkg::K_NUMBER, lx_start, lx_wlen, lx_acc,
                                           lx_ovf);
            ctl_pkg::PH_DOTDOT: begin
                push_token(ctl_pkg::P_DOT, lx_start, 1, 0, 0);
                push_token(ctl_pkg::P_DOT, lx_start + 16'd1, 1, 0, 0);
            end
            default: push_token(lx_phase, lx_start,
                                (lx_phase == ctl_pkg::P_SHL || lx_phase == ctl_pkg::P_SHR)
                                ? 2 : 1, 0, 0);
        endcase
        lx_phase = ctl_pkg::PH_IDLE;
    endfunction

    function automatic logic [6:0] two_char(logic [6:0] k, logic [7:0] c);
        case (k)
            ctl_pkg::P_AMP:   return c == "&" ? ctl_pkg::P_AMPAMP
                                   : c == "=" ? ctl_pkg::P_AMPEQ : 0;
            ctl_pkg::P_STAR:  return c == "=" ? ctl_pkg::P_STAREQ : 0;
            ctl_pkg::P_PLUS:  return c == "+" ? ctl_pkg::P_PLUSPLUS
                                   : c == "=" ? ctl_pkg::P_PLUSEQ : 0;
            ctl_pkg::P_MINUS: return c == ">" ? ctl_pkg::P_ARROW
                                   : c == "-" ? ctl_pkg::P_MINMIN
                                   : c == "=" ? ctl_pkg::P_MINEQ : 0;
            ctl_pkg::P_EXCL:  return c == "=" ? ctl_pkg::P_EXCLEQ : 0;
            ctl_pkg::P_SLASH: return c == "=" ? ctl_pkg::P_SLASHEQ : 0;
            ctl_pkg::P_PCT:   return c == "=" ? ctl_pkg::P_PCTEQ : 0;
            ctl_pkg::P_LT:    return c == "=" ? ctl_pkg::P_LE : 0;
            ctl_pkg::P_GT:    return c == "=" ? ctl_pkg::P_GE : 0;
            ctl_pkg::P_CARET: return c == "=" ? ctl_pkg::P_CARETEQ : 0;
            ctl_pkg::P_PIPE:  return c == "|" ? ctl_pkg::P_PIPEPIPE
                                   : c == "=" ? ctl_pkg::P_PIPEEQ : 0;
            ctl_pkg::P_EQ:    return c == "=" ? ctl_pkg::P_EQEQ : 0;
            ctl_pkg::P_HASH:  return c == "#" ? ctl_pkg::P_HASHHASH
                                   : c == "@" ? ctl_pkg::P_HASHAT : 0;
            default: return 0;
        endcase
    endfunction

    function automatic void begin_token(logic [7:0] c);
        logic [6:0] k;
        bit hold;
        if (is_ws(c)) return;
        lx_start = lx_pos;
        if (is_alpha(c)) begin
            lx_prefix[0] = c; lx_wlen = 1; lx_phase = ctl_pkg::PH_IDENT;
            return;
        end
        if (is_dig(c)) begin
            lx_acc = 0; lx_ovf = 0; lx_wlen = 1; add_digit(c);
            lx_phase = ctl_pkg::PH_NUMBER;
            return;
        end
        hold = 1;
        case (c)
            "[": begin k = ctl_pkg::P_LSQ; hold = 0; end
            "]": begin k = ctl_pkg::P_RSQ; hold = 0; end
            "(": begin k = ctl_pkg::P_LPAR; hold = 0; end
            ")": begin k = ctl_pkg::P_RPAR; hold = 0; end
            "{": begin k = ctl_pkg::P_LBR; hold = 0; end
            "}": begin k = ctl_pkg::P_RBR; hold = 0; end
            "~": begin k = ctl_pkg::P_TILDE; hold = 0; end
            "?": begin k = ctl_pkg::P_QUEST; hold = 0; end
            ":": begin k = ctl_pkg::P_COLON; hold = 0; end
            ";": begin k = ctl_pkg::P_SEMI; hold = 0; end
            ",": begin k = ctl_pkg::P_COMMA; hold = 0; end
            ".": k = ctl_pkg::P_DOT;
            "&": k = ctl_pkg::P_AMP;
            "*": k = ctl_pkg::P_STAR;
            "+": k = ctl_pkg::P_PLUS;
            "-": k = ctl_pkg::P_MINUS;
            "!": k = ctl_pkg::P_EXCL;
            "/": k = ctl_pkg::P_SLASH;
            "%": k = ctl_pkg::P_PCT;
            "<": k = ctl_pkg::P_LT;
            ">": k = ctl_pkg::P_GT;
            "^": k = ctl_pkg::P_CARET;
            "|": k = ctl_pkg::P_PIPE;
            "=": k = ctl_pkg::P_EQ;
            "#": k = ctl_pkg::P_HASH;
            default: begin
                push_token(ctl_pkg::K_UNKNOWN, lx_pos, 1, 0, 0);
                return;
            end
        endcase
        if (hold) lx_phase = k;
        else push_token(k, lx_pos, 1, 0, 0);
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [6:0] k;
        if (lx_phase == ctl_pkg::PH_IDENT && (is_alpha(c) || is_dig(c))) begin
            if (lx_wlen < 8) lx_prefix[lx_wlen] = c;
            if (lx_wlen != 16'hffff) lx_wlen++;
            return;
        end
        if (lx_phase == ctl_pkg::PH_NUMBER && is_dig(c)) begin
            add_digit(c);
            if (lx_wlen != 16'hffff) lx_wlen++;
            return;
        end
        if (lx_phase == ctl_pkg::PH_DOTDOT && c == ".") begin
            push_token(ctl_pkg::P_ELLIP, lx_start, 3, 0, 0); lx_phase = ctl_pkg::PH_IDLE;
            return;
        end
        if ((lx_phase == ctl_pkg::P_SHL || lx_phase == ctl_pkg::P_SHR) && c == "=") begin
            push_token(lx_phase == ctl_pkg::P_SHL ? ctl_pkg::P_SHLEQ : ctl_pkg::P_SHREQ,
                       lx_start, 3, 0, 0);
            lx_phase = ctl_pkg::PH_IDLE;
            return;
        end
        if (lx_phase == ctl_pkg::P_DOT && c == ".") begin
            lx_phase = ctl_pkg::PH_DOTDOT; return;
        end
        if (lx_phase == ctl_pkg::P_LT && c == "<") begin
            lx_phase = ctl_pkg::P_SHL; return;
        end
        if (lx_phase == ctl_pkg::P_GT && c == ">") begin
            lx_phase = ctl_pkg::P_SHR; return;
        end
        if (lx_phase >= ctl_pkg::P_LSQ && lx_phase <= ctl_pkg::P_HASH) begin
            k = two_char(lx_phase, c);
            if (k != 0) begin
                push_token(k, lx_start, 2, 0, 0); lx_phase = ctl_pkg::PH_IDLE;
                return;
            end
        end
        flush_word();
        begin_token(c);
    endfunction

    function automatic int predict_tokens(logic [7:0] c, logic e);
        run_tokens.delete();
        if (e) begin
            flush_word();
            push_token(ctl_pkg::K_EOF, lx_pos, 0, 0, 0);
            lx_pos = 0; lx_start = 0; lx_wlen = 0; lx_acc = 0; lx_ovf = 0;
        end else begin
            lex_byte(c);
            lx_pos++;
        end
        if (run_tokens.size() > 0) run_tokens[$].last = 1;
        foreach (run_tokens[i]) token_fifo.push_back(run_tokens[i]);
        return run_tokens.size();
    endfunction

    // drive one transaction and record its expected tokens
    task automatic send_item(logic [7:0] c, logic e);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= c;
        i_end_mark <= e;
        do @(posedge i_clk); while (!o_in_ready);
        void'(predict_tokens(c, e));
        n_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_checked(t_row r);
        int n;
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= r.b;
        i_end_mark <= r.e;
        do @(posedge i_clk); while (!o_in_ready);
        n = predict_tokens(r.b, r.e);
        n_items++;
        if (r.chk && (n == 0 || token_fifo[$].kind != r.kind || token_fifo[$].start != r.start
                      || token_fifo[$].len != r.len)) begin
            $error("directed row byte=%0h: token_kind expected %0d predicted %0d",
                   r.b, r.kind, n ? token_fifo[$].kind : 0);
            fail_count++;
        end
    endtask

    // output side: random stall per token, then compare
    initial begin
        t_token_exp t;
        int gap;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = stim_done ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            if (token_fifo.size() == 0) begin
                $error("unexpected token kind %0d", o_token_kind);
                fail_count++;
            end else begin
                t = token_fifo.pop_front();
                if (o_token_kind !== t.kind) begin
                    $error("token_kind expected %0d actual %0d", t.kind, o_token_kind);
                    fail_count++;
                end
                if (o_start_offset !== t.start) begin
                    $error("start_offset expected %0d actual %0d", t.start,
                           o_start_offset);
                    fail_count++;
                end
                if (o_token_length !== t.len) begin
                    $error("token_length expected %0d actual %0d", t.len,
                           o_token_length);
                    fail_count++;
                end
                if (o_number_value !== t.val) begin
                    $error("number_value expected %0d actual %0d", t.val,
                           o_number_value);
                    fail_count++;
                end
                if (o_number_overflow !== t.ovf) begin
                    $error("number_overflow expected %0d actual %0d", t.ovf,
                           o_number_overflow);
                    fail_count++;
                end
                if (o_last_of_run !== t.last) begin
                    $error("last_of_run expected %0d actual %0d", t.last,
                           o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        string frags [24] = '{"int ", "while", "volatile", "continue", "sizeof",
            "unsigned ", "register", "_x9", "abcdefghij", "volatilex", "123",
            "18446744073709551615", "18446744073709551616", "99999999999999999999999",
            "...", "..", "<<=", ">>=", "->", "##", "#@", "a+=b", "x<<y", "0"};
        string puncts = "[](){}.&*+-~!/%<>^|?:;=,#@$`'\"\\";
        int kind_sel;
        logic [7:0] c;

        fail_count = 0;
        n_items = 0;
        stim_done = 0;
        i_in_valid = 1'b0;
        i_byte_in = '0;
        i_end_mark = 1'b0;
        lx_pos = 0; lx_start = 0; lx_phase = ctl_pkg::PH_IDLE; lx_wlen = 0; lx_acc = 0;
        lx_ovf = 0;
        foreach (lx_prefix[i]) lx_prefix[i] = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: eof right after reset, control and high bytes, extremes
        rows.push_back('{8'h00, 1'b1, 1'b1, ctl_pkg::K_EOF, 16'd0, 16'd0});
        rows.push_back('{8'h00, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 16'd0, 16'd1});
        rows.push_back('{8'hff, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 16'd1, 16'd1});
        rows.push_back('{8'h80, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 16'd2, 16'd1});
        rows.push_back('{8'h7f, 1'b0, 1'b1, ctl_pkg::K_UNKNOWN, 16'd3, 16'd1});
        rows.push_back('{8'h0b, 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{8'h0c, 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{"[", 1'b0, 1'b1, ctl_pkg::P_LSQ, 16'd6, 16'd1});
        rows.push_back('{"~", 1'b0, 1'b1, ctl_pkg::P_TILDE, 16'd7, 16'd1});
        rows.push_back('{"<", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{"<", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{"=", 1'b0, 1'b1, ctl_pkg::P_SHLEQ, 16'd8, 16'd3});
        rows.push_back('{".", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{".", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{"a", 1'b0, 1'b1, ctl_pkg::P_DOT, 16'd12, 16'd1});
        rows.push_back('{"#", 1'b0, 1'b1, ctl_pkg::K_IDENT, 16'd13, 16'd1});
        rows.push_back('{8'h00, 1'b1, 1'b1, ctl_pkg::K_EOF, 16'd15, 16'd0});
        rows.push_back('{">", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{">", 1'b0, 1'b0, '0, '0, '0});
        rows.push_back('{8'hff, 1'b1, 1'b1, ctl_pkg::K_EOF, 16'd2, 16'd0});
        foreach (rows[i]) send_checked(rows[i]);

        // let everything drain before going on
        i_in_valid <= 1'b0;
        while (token_fifo.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // random: mostly well-formed fragments, some noise
        while (n_items < 168) begin
            kind_sel = $urandom_range(0, 9);
            if (kind_sel < 4) begin
                send_text(frags[$urandom_range(0, 23)]);
            end else if (kind_sel < 7) begin
                c = puncts[$urandom_range(0, puncts.len() - 1)];
                send_item(c, 1'b0);
            end else if (kind_sel < 9) begin
                c = 8'($urandom_range(0, 255));
                send_item(c, 1'b0);
            end else begin
                send_item(8'($urandom_range(0, 255)), 1'b1);
            end
            if ($urandom_range(0, 2) == 0) send_item(" ", 1'b0);
        end
        send_item(8'h00, 1'b1);
        i_in_valid <= 1'b0;
        stim_done = 1;

        while (token_fifo.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && token_fifo.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
